// ----- src/lic_pkg.sv -----
`default_nettype none

package lic_pkg;

  localparam int MAX_PACKET_BYTES = 65535;
  localparam int IDX_W = $clog2(MAX_PACKET_BYTES);

  localparam logic [1:0] MODE_TCP  = 2'd0;
  localparam logic [1:0] MODE_UDP  = 2'd1;
  localparam logic [1:0] MODE_ICMP = 2'd2;
  localparam logic [1:0] MODE_NONE = 2'd3;

  localparam logic [5:0] MIN_HDR_BYTES = 6'd20;
  localparam logic [3:0] MIN_IHL       = 4'd5;

  localparam logic [4:0] OFF_TCP  = 5'd16;
  localparam logic [4:0] OFF_UDP  = 5'd6;
  localparam logic [4:0] OFF_ICMP = 5'd2;

  localparam logic [16:0] PROTO_NUM_TCP = 17'd6;
  localparam logic [16:0] PROTO_NUM_UDP = 17'd17;

  localparam int ADDR_FIRST = 12;
  localparam int ADDR_LAST  = 19;

  function automatic logic [4:0] field_offset(input logic [1:0] mode);
    logic [4:0] off;
    case (mode)
      MODE_TCP: off = OFF_TCP;
      MODE_UDP: off = OFF_UDP;
      default:  off = OFF_ICMP;
    endcase
    return off;
  endfunction

endpackage

`default_nettype wire

// ----- src/l4_internet_checksum_top.sv -----
// Result path: after the final byte of a packet is accepted, its sum passes the input stage,
// the wide sum stage, and the fold and complement into the output register that raises out_valid.
// Throughput: one byte per cycle; the three-stage result path only holds input when every
// stage is full and the output item is not being taken.
// Reset: synchronous rst clears the packet state and all stage valid flags.
`default_nettype none

module l4_internet_checksum_top
  import lic_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  pkt_byte,
  input  wire logic [1:0]  protocol_sel,
  input  wire logic        pkt_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      checksum,
  output logic [6:0]       checksum_offset
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PACKET_BYTES - 1);

  logic [IDX_W-1:0] byte_index;
  logic [5:0]       header_bytes;
  logic [31:0]      sum_acc;
  logic [7:0]       high_byte_hold;
  logic [1:0]       proto_latched;

  logic [IDX_W-1:0] byte_index_next;
  logic [5:0]       header_bytes_next;
  logic [31:0]      sum_acc_next;
  logic [7:0]       high_byte_hold_next;
  logic [1:0]       proto_latched_next;

  logic        r1_valid;
  logic [31:0] r1_sum;
  logic [16:0] r1_extra;
  logic [6:0]  r1_off;
  logic        r2_valid;
  logic [31:0] r2_sum;
  logic [6:0]  r2_off;

  logic        accept;
  logic        out_load;
  logic        r2_load;

  logic             first;
  logic [5:0]       hdr;
  logic [1:0]       proto;
  logic             pseudo;
  logic [4:0]       coff;
  logic             addr_phase;
  logic             in_seg;
  logic [IDX_W-1:0] k;
  logic [IDX_W-1:0] seglen;
  logic [7:0]       v;
  logic [7:0]       data;
  logic             add_en;
  logic             pkt_end;
  logic             has_result;
  logic [15:0]      fin_word;
  logic [16:0]      extra;
  logic [16:0]      fold1;
  logic [15:0]      fold2;

  assign out_load = r2_valid && (!out_valid || out_ready);
  assign r2_load  = r1_valid && (!r2_valid || out_load);
  assign in_ready = !r1_valid || r2_load;
  assign accept   = in_valid && in_ready;

  always_comb begin
    first = (byte_index == '0);
    if (first) begin
      hdr   = (pkt_byte[3:0] < MIN_IHL) ? MIN_HDR_BYTES : {pkt_byte[3:0], 2'b00};
      proto = protocol_sel;
    end else begin
      hdr   = header_bytes;
      proto = proto_latched;
    end
    pseudo     = (proto == MODE_TCP) || (proto == MODE_UDP);
    coff       = field_offset(proto);
    addr_phase = pseudo && (byte_index >= IDX_W'(ADDR_FIRST)) &&
                 (byte_index <= IDX_W'(ADDR_LAST));
    in_seg     = byte_index >= IDX_W'(hdr);
    k          = byte_index - IDX_W'(hdr);
    seglen     = in_seg ? k + 1'b1 : '0;
    v          = ((k == IDX_W'(coff)) || (k == IDX_W'(coff) + 1'b1)) ? 8'h00 : pkt_byte;
    data       = addr_phase ? pkt_byte : v;
    add_en     = (addr_phase || in_seg) && k[0];
    pkt_end    = pkt_last || (byte_index >= LAST_IDX);
    has_result = pkt_end && in_seg && (proto != MODE_NONE);
    fin_word   = k[0] ? {high_byte_hold, v} : {v, 8'h00};
    if (pseudo) begin
      extra = ((proto == MODE_TCP) ? PROTO_NUM_TCP : PROTO_NUM_UDP) + 17'(seglen);
    end else begin
      extra = '0;
    end

    byte_index_next     = byte_index + 1'b1;
    header_bytes_next   = hdr;
    proto_latched_next  = proto;
    high_byte_hold_next = high_byte_hold;
    sum_acc_next        = sum_acc + (add_en ? {16'h0000, high_byte_hold, data} : 32'h0);
    if ((addr_phase || in_seg) && !k[0]) begin
      high_byte_hold_next = data;
    end
    if (pkt_end) begin
      byte_index_next     = '0;
      header_bytes_next   = '0;
      proto_latched_next  = '0;
      high_byte_hold_next = '0;
      sum_acc_next        = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index     <= '0;
      header_bytes   <= '0;
      sum_acc        <= '0;
      high_byte_hold <= '0;
      proto_latched  <= '0;
    end else if (accept) begin
      byte_index     <= byte_index_next;
      header_bytes   <= header_bytes_next;
      sum_acc        <= sum_acc_next;
      high_byte_hold <= high_byte_hold_next;
      proto_latched  <= proto_latched_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_valid <= 1'b0;
    end else if (in_ready) begin
      r1_valid <= accept && has_result;
    end
    if (accept) begin
      r1_sum   <= sum_acc + {16'h0000, fin_word};
      r1_extra <= extra;
      r1_off   <= 7'(hdr) + 7'(coff);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r2_valid <= 1'b0;
    end else if (!r2_valid || out_load) begin
      r2_valid <= r1_valid;
    end
    if (r2_load) begin
      r2_sum <= r1_sum + {15'h0000, r1_extra};
      r2_off <= r1_off;
    end
  end

  assign fold1 = {1'b0, r2_sum[31:16]} + {1'b0, r2_sum[15:0]};
  assign fold2 = fold1[15:0] + {15'h0000, fold1[16]};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= r2_valid;
    end
    if (out_load) begin
      checksum        <= ~fold2;
      checksum_offset <= r2_off;
    end
  end

  // The header length is always a whole number of words of at least twenty bytes.
  a_hdr_len: assert property (@(posedge clk) disable iff (rst)
    (byte_index != '0) |-> (header_bytes >= MIN_HDR_BYTES) && (header_bytes[1:0] == 2'b00))
    else $error("header length out of range during a packet");

  // A byte flagged as the last one returns the packet state to its start.
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && pkt_last |=> (byte_index == '0) && (sum_acc == '0))
    else $error("packet state not cleared after the final item");

  // Input is only held off when every stage of the result path is occupied.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> r1_valid && r2_valid && out_valid && !out_ready)
    else $error("input stalled with room in the result path");

  // The offset of the field lies between the shortest and longest header cases.
  a_offset: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (checksum_offset >= 7'd22) && (checksum_offset <= 7'd76))
    else $error("checksum offset out of range");

endmodule

`default_nettype wire

// ----- tb/sv/tb_l4_internet_checksum_top.sv -----
`default_nettype none

module tb_l4_internet_checksum_top;
  import lic_pkg::*;

  typedef struct packed {
    logic [15:0] sum_field;
    logic [6:0]  offset;
  } checksum_item_t;

  typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_MASK, RX_SPARSE} rx_pattern_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  pkt_byte = 8'd0;
  logic [1:0]  protocol_sel = 2'd0;
  logic        pkt_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] checksum;
  logic [6:0]  checksum_offset;

  checksum_item_t pending_checksums[$];
  checksum_item_t oldest_checksum;

  logic [15:0] seg_idx = '0;
  logic [5:0]  seg_hdr_bytes = '0;
  logic [31:0] seg_sum = '0;
  logic [7:0]  seg_hold = '0;
  logic [1:0]  seg_mode = '0;

  int mismatches = 0;
  int bytes_sent = 0;
  int packets_sent = 0;
  int checksums_predicted = 0;
  int checksums_checked = 0;
  int silent_packets = 0;
  int burst_left = 0;

  rx_pattern_t rx_pattern = RX_ALWAYS;
  logic [15:0] rx_mask = 16'hffff;
  logic [3:0]  rx_phase = '0;
  int          rx_hold = 0;

  l4_internet_checksum_top DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .pkt_byte(pkt_byte),
    .protocol_sel(protocol_sel),
    .pkt_last(pkt_last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .checksum(checksum),
    .checksum_offset(checksum_offset)
  );

  always #6 clk = ~clk;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic advance_checksum(input logic [7:0] b, input logic [1:0] sel, input logic last);
    logic [4:0]     off;
    logic           pseudo;
    logic [15:0]    k;
    logic [7:0]     v;
    logic [31:0]    s;
    logic [15:0]    seglen;
    checksum_item_t item;
    if (seg_idx == 0) begin
      seg_hdr_bytes = (b[3:0] < MIN_IHL) ? MIN_HDR_BYTES : {b[3:0], 2'b00};
      seg_mode = sel;
    end
    pseudo = (seg_mode == MODE_TCP) || (seg_mode == MODE_UDP);
    case (seg_mode)
      MODE_TCP: off = OFF_TCP;
      MODE_UDP: off = OFF_UDP;
      default:  off = OFF_ICMP;
    endcase
    if (pseudo && seg_idx >= ADDR_FIRST && seg_idx <= ADDR_LAST) begin
      if (!seg_idx[0]) seg_hold = b;
      else seg_sum = seg_sum + {16'd0, seg_hold, b};
    end
    if (seg_idx >= seg_hdr_bytes) begin
      k = seg_idx - seg_hdr_bytes;
      v = (k == off || k == off + 16'd1) ? 8'd0 : b;
      if (!k[0]) seg_hold = v;
      else seg_sum = seg_sum + {16'd0, seg_hold, v};
    end
    if (last || seg_idx >= MAX_PACKET_BYTES - 1) begin
      seglen = (seg_idx >= seg_hdr_bytes) ? seg_idx + 16'd1 - seg_hdr_bytes : 16'd0;
      if (seglen != 0 && seg_mode != MODE_NONE) begin
        s = seg_sum;
        if (seglen[0]) s = s + {16'd0, seg_hold, 8'd0};
        if (pseudo) begin
          s = s + ((seg_mode == MODE_TCP) ? 32'(PROTO_NUM_TCP) : 32'(PROTO_NUM_UDP));
          s = s + {16'd0, seglen};
        end
        s = {16'd0, s[31:16]} + {16'd0, s[15:0]};
        s = {16'd0, s[31:16]} + {16'd0, s[15:0]};
        item.sum_field = ~s[15:0];
        item.offset = 7'(seg_hdr_bytes) + 7'(off);
        pending_checksums.push_back(item);
        checksums_predicted++;
      end else begin
        silent_packets++;
      end
      seg_idx = '0;
      seg_hdr_bytes = '0;
      seg_sum = '0;
      seg_hold = '0;
      seg_mode = '0;
    end else begin
      seg_idx = seg_idx + 16'd1;
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) advance_checksum(pkt_byte, protocol_sel, pkt_last);
      if (out_valid && out_ready) begin
        if (pending_checksums.size() == 0) begin
          report_mismatch("unexpected result, checksum", checksum, 0);
        end else begin
          oldest_checksum = pending_checksums.pop_front();
          checksums_checked++;
          if (checksum !== oldest_checksum.sum_field)
            report_mismatch("checksum", checksum, oldest_checksum.sum_field);
          if (checksum_offset !== oldest_checksum.offset)
            report_mismatch("checksum_offset", checksum_offset, oldest_checksum.offset);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rx_hold == 0) begin
      rx_hold <= $urandom_range(40, 400);
      rx_pattern <= rx_pattern_t'($urandom_range(0, 3));
      rx_mask <= 16'($urandom) | 16'h0001;
    end else begin
      rx_hold <= rx_hold - 1;
    end
    rx_phase <= rx_phase + 4'd1;
    case (rx_pattern)
      RX_ALWAYS: out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RX_MASK:   out_ready <= rx_mask[rx_phase];
      default:   out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  task automatic send_byte(input logic [7:0] b, input logic [1:0] sel, input logic last);
    int gap;
    in_valid <= 1'b1;
    pkt_byte <= b;
    protocol_sel <= sel;
    pkt_last <= last;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    bytes_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // A negative segment length ends the packet inside the header. A fill of -1 means random
  // bytes. With no_last set the final byte is sent without pkt_last, so the packet is left open.
  task automatic send_packet(input logic [1:0] mode, input logic [3:0] ihl, input int seg_len,
                             input int fill, input bit no_last);
    int          hdr;
    int          total;
    logic [7:0]  b;
    logic [1:0]  sel;
    hdr = (ihl < MIN_IHL) ? 20 : ihl * 4;
    total = hdr + seg_len;
    if (total < 1) total = 1;
    for (int i = 0; i < total; i++) begin
      b = (fill < 0) ? 8'($urandom) : 8'(fill);
      sel = 2'($urandom);
      if (i == 0) begin
        b[3:0] = ihl;
        sel = mode;
      end
      send_byte(b, sel, (i == total - 1) && !no_last);
    end
    packets_sent++;
  endtask

  task automatic test_protocol_modes();
    send_packet(MODE_TCP, 4'd5, 24, -1, 1'b0);
    send_packet(MODE_TCP, 4'd5, 31, -1, 1'b0);
    send_packet(MODE_UDP, 4'd5, 8, -1, 1'b0);
    send_packet(MODE_UDP, 4'd5, 9, -1, 1'b0);
    send_packet(MODE_ICMP, 4'd5, 12, -1, 1'b0);
    send_packet(MODE_ICMP, 4'd5, 7, -1, 1'b0);
    send_packet(MODE_NONE, 4'd5, 20, -1, 1'b0);
  endtask

  task automatic test_header_lengths();
    send_packet(MODE_TCP, 4'd0, 10, -1, 1'b0);
    send_packet(MODE_UDP, 4'd4, 5, -1, 1'b0);
    send_packet(MODE_TCP, 4'd15, 40, -1, 1'b0);
    send_packet(MODE_ICMP, 4'd6, 3, -1, 1'b0);
  endtask

  task automatic test_empty_segments();
    send_packet(MODE_TCP, 4'd5, 0, -1, 1'b0);
    send_packet(MODE_UDP, 4'd15, -30, -1, 1'b0);
    send_packet(MODE_ICMP, 4'd5, -19, -1, 1'b0);
    send_packet(MODE_TCP, 4'd5, -8, -1, 1'b0);
  endtask

  task automatic test_short_segments();
    send_packet(MODE_TCP, 4'd5, 1, -1, 1'b0);
    send_packet(MODE_TCP, 4'd5, 16, -1, 1'b0);
    send_packet(MODE_TCP, 4'd5, 17, -1, 1'b0);
    send_packet(MODE_UDP, 4'd5, 6, -1, 1'b0);
    send_packet(MODE_UDP, 4'd5, 7, -1, 1'b0);
    send_packet(MODE_ICMP, 4'd5, 2, -1, 1'b0);
  endtask

  task automatic test_extreme_bytes();
    send_packet(MODE_TCP, 4'd15, 40, 8'hff, 1'b0);
    send_packet(MODE_UDP, 4'd5, 20, 8'h00, 1'b0);
    send_packet(MODE_ICMP, 4'd5, 4, 8'h00, 1'b0);
    send_packet(MODE_ICMP, 4'd5, 9, 8'hff, 1'b0);
  endtask

  task automatic test_random_packets();
    int          first_byte;
    int          kind;
    logic [3:0]  ihl;
    first_byte = bytes_sent;
    while (bytes_sent - first_byte < 250) begin
      kind = $urandom_range(0, 9);
      if (kind < 8) begin
        ihl = ($urandom_range(0, 9) < 7) ? 4'd5 : 4'($urandom_range(5, 15));
        send_packet(2'($urandom_range(0, 2)), ihl, $urandom_range(1, 40), -1, 1'b0);
      end else if (kind == 8) begin
        send_packet(2'($urandom), 4'($urandom_range(0, 4)), $urandom_range(0, 24), -1, 1'b0);
      end else begin
        send_packet(2'($urandom), 4'($urandom), -int'($urandom_range(0, 40)), -1, 1'b0);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_protocol_modes();
    test_header_lengths();
    test_empty_segments();
    test_short_segments();
    test_extreme_bytes();
    test_random_packets();
    in_valid <= 1'b0;
    while (pending_checksums.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d packets in %0d bytes over TCP, UDP, ICMP and the unused mode.",
             packets_sent, bytes_sent);
    $display("Checked %0d of %0d expected checksums; %0d packets ended with no result.",
             checksums_checked, checksums_predicted, silent_packets);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches.", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #(12 * 2000000);
    $display("Timed out with %0d checksums still expected.", pending_checksums.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
src/lic_pkg.sv
src/l4_internet_checksum_top.sv
tb/sv/tb_l4_internet_checksum_top.sv
